### rtl/gsrp_pkg.sv
// ---------------------------------------------------------------------------
// gsrp_pkg: shared constants, types and helpers
// Fixed-point constants, request field layout and the log2/exp2 step
// helpers used by the gas sensor conversion pipeline.
// ---------------------------------------------------------------------------
package gsrp_pkg;

   localparam int RAW_BITS  = 10;
   localparam int FRAC_BITS = 12;
   localparam int REQ_W     = ((RAW_BITS + 32 + 7) / 8) * 8;

   // full scale * vref * 16 stays below 2^(RAW_BITS+20)
   localparam int DIVD_W      = RAW_BITS + 20;
   localparam int DIV_BITS    = 5;
   localparam int DIV_STAGES  = (DIVD_W + DIV_BITS - 1) / DIV_BITS;
   localparam int MUL_LO_W    = 15;

   localparam int N_W         = 37;
   localparam int CDIV_BITS   = 2;
   localparam int CDIV_STAGES = 32 / CDIV_BITS;

   localparam int LOG_STEPS = 16;
   localparam int LOG_LAT   = LOG_STEPS + 1;
   localparam int EXP_STEPS = 16;
   localparam int EXP_LAT   = EXP_STEPS + 1;
   localparam int Y_W       = 28;

   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [31:0] LOAD_RESET = 32'd655360;
   localparam logic [31:0] R0_RESET   = 32'd5021941;
   localparam logic [15:0] VREF_RESET = 16'd20480;
   localparam logic [15:0] ATMO_RESET = 16'd400;

   localparam logic [1:0] CSR_LOAD = 2'd0;
   localparam logic [1:0] CSR_R0   = 2'd1;
   localparam logic [1:0] CSR_VREF = 2'd2;
   localparam logic [1:0] CSR_ATMO = 2'd3;

   localparam logic [1:0] KIND_PPM = 2'd0;
   localparam logic [1:0] KIND_RES = 2'd1;
   localparam logic [1:0] KIND_CAL = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RAW_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   localparam logic [31:0] PARA_Q16   = 32'd7641633;
   localparam logic [18:0] PARB_Q16   = 19'd181471;
   localparam logic [18:0] INVB_Q16   = 19'd23667;
   localparam logic [16:0] CORR_SCALE = 17'd100000;

   // factor N = 35 T^2 - 695808 T + 9144926208 - 46080 (H - 8448)
   localparam logic signed [40:0] N_SQ  = 41'sd35;
   localparam logic signed [36:0] N_LIN = 37'sd695808;
   localparam logic signed [40:0] N_OFS = 41'sd9144926208;
   localparam logic signed [32:0] N_HUM = 33'sd46080;
   localparam logic signed [32:0] N_H0  = 33'sd8448;

   typedef struct packed {
      logic                valid;
      logic [1:0]          kind;
      logic [RAW_BITS-1:0] raw;
      logic                raw_zero;
      logic                corr;
      logic                sat;
      logic                r_ovf;
      logic                c_ovf;
      logic                n_bad;
      logic [N_W-1:0]      n;
      logic [31:0]         r;
      logic                r_zero;
   } item_type;

   // one squaring step of the log2 mantissa: {fraction bit, new mantissa}
   function automatic logic [32:0] log2_sq_step(input logic [31:0] m);
      logic [63:0] sq;
      sq = 64'(m) * 64'(m);
      if (sq[63]) begin
         return {1'b1, sq[63:32]};
      end
      return {1'b0, sq[62:31]};
   endfunction

   function automatic logic [20:0] log2_q16_f(input logic [31:0] x);
      logic [4:0]  msb;
      logic [31:0] m;
      logic [15:0] frac;
      logic [32:0] st;
      msb = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            msb = 5'(i);
         end
      end
      m = x << (5'd31 - msb);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         st = log2_sq_step(m);
         m = st[31:0];
         frac = {frac[14:0], st[32]};
      end
      return {msb, frac};
   endfunction

   function automatic logic [63:0] isqrt_f(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bt;
      rem = v;
      res = '0;
      bt  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q30
   function automatic logic [31:0] exp2_coef_f(input int k);
      logic [63:0] c;
      c = 64'd1 << 31;
      for (int i = 1; i <= 16; i++) begin
         if (i <= k) begin
            c = isqrt_f(c << 30);
         end
      end
      return c[31:0];
   endfunction

   localparam int LOG2A_I = int'(log2_q16_f(PARA_Q16)) - 1048576;

endpackage

### rtl/gas_sensor_raw_to_ppm_core.sv
// ---------------------------------------------------------------------------
// gas_sensor_raw_to_ppm_core: gas sensor reading to resistance / CO2 ppm
// Fixed-point divider, resistance multiply, temperature/humidity
// correction divider, log2 and exp2 pipelines.
// ---------------------------------------------------------------------------
//  channel   direction   transfer            payload
//  req_*     in          tvalid & tready     tuser kind, tdata reading fields
//  rsp_*     out         tvalid & tready     tuser status, tdata value
//  csr_*     in          valid & ready       index, data (always ready)
//
//  One request per cycle while results are taken; the pipeline holds the
//  16-stage correction divider and the 17-stage log2 and exp2 chains.
//  Reset clears all valid bits; configuration registers return to defaults.
//  A result not taken freezes the whole pipeline, req_tready falls with it.
// ---------------------------------------------------------------------------
module gas_sensor_raw_to_ppm_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // raw, apply_correction, temperature, humidity, zero fill
   input  logic [gsrp_pkg::REQ_W-1:0] req_tdata,
   // kind
   input  logic [1:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // value
   output logic [31:0]                rsp_tdata,
   // status
   output logic [1:0]                 rsp_tuser,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_data
);

   localparam int RB = gsrp_pkg::RAW_BITS;
   localparam int DW = gsrp_pkg::DIVD_W;
   localparam int NW = gsrp_pkg::N_W;

   logic ce;

   // configuration
   logic [31:0] load_ff, r0_ff;
   logic [15:0] vref_ff, atmo_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= gsrp_pkg::LOAD_RESET;
         r0_ff   <= gsrp_pkg::R0_RESET;
         vref_ff <= gsrp_pkg::VREF_RESET;
         atmo_ff <= gsrp_pkg::ATMO_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            gsrp_pkg::CSR_LOAD: load_ff <= csr_data;
            gsrp_pkg::CSR_R0:   r0_ff   <= csr_data;
            gsrp_pkg::CSR_VREF: vref_ff <= csr_data[15:0];
            gsrp_pkg::CSR_ATMO: atmo_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic                  rsp_tvalid_ff;
   logic [31:0]           rsp_value_ff;
   logic [1:0]            rsp_status_ff;

   assign ce         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = ce;

   // input stage
   gsrp_pkg::item_type  p0_in, p0_ff, p1_ff, p2_in, p2_ff;
   logic signed [15:0]  temp0_ff;
   logic [14:0]         hum0_ff;

   always_comb begin
      p0_in          = '0;
      p0_in.valid    = req_tvalid;
      p0_in.kind     = req_tuser;
      p0_in.raw      = req_tdata[RB-1:0];
      p0_in.raw_zero = (req_tdata[RB-1:0] == '0);
      p0_in.corr     = req_tdata[RB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff.valid <= 1'b0;
      end else if (ce) begin
         p0_ff    <= p0_in;
         temp0_ff <= $signed(req_tdata[RB+16:RB+1]);
         hum0_ff  <= req_tdata[RB+31:RB+17];
      end
   end

   // correction factor terms
   logic signed [31:0] tsq_ff;
   logic signed [36:0] tlin_ff;
   logic signed [32:0] hlin_ff;
   logic signed [40:0] n_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid <= 1'b0;
      end else if (ce) begin
         p1_ff   <= p0_ff;
         tsq_ff  <= temp0_ff * temp0_ff;
         tlin_ff <= 37'(temp0_ff) * gsrp_pkg::N_LIN;
         hlin_ff <= ($signed({18'd0, hum0_ff}) - gsrp_pkg::N_H0) * gsrp_pkg::N_HUM;
      end
   end

   assign n_sum = 41'(tsq_ff) * gsrp_pkg::N_SQ - 41'(tlin_ff) + gsrp_pkg::N_OFS
                  - 41'(hlin_ff);

   always_comb begin
      p2_in       = p1_ff;
      p2_in.n_bad = (n_sum <= 41'sd0);
      p2_in.n     = n_sum[NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ff.valid <= 1'b0;
      end else if (ce) begin
         p2_ff <= p2_in;
      end
   end

   // full-scale ratio divider: (FULL * vref * 16) / raw
   logic [DW-1:0] divd;
   assign divd = {({vref_ff, {RB{1'b0}}} - (RB+16)'(vref_ff)), 4'b0000};

   gsrp_pkg::item_type div_item_ff [gsrp_pkg::DIV_STAGES];
   logic [RB-1:0]      div_rem_ff  [gsrp_pkg::DIV_STAGES];
   logic [DW-1:0]      div_x_ff    [gsrp_pkg::DIV_STAGES];

   for (genvar s = 0; s < gsrp_pkg::DIV_STAGES; s++) begin : g_div
      gsrp_pkg::item_type it_src;
      logic [RB-1:0]      rem_src, rem_in;
      logic [DW-1:0]      x_src, x_in;
      if (s == 0) begin : g_first
         assign it_src  = p2_ff;
         assign rem_src = '0;
         assign x_src   = divd;
      end else begin : g_next
         assign it_src  = div_item_ff[s-1];
         assign rem_src = div_rem_ff[s-1];
         assign x_src   = div_x_ff[s-1];
      end
      always_comb begin
         logic [RB:0] tmp;
         rem_in = rem_src;
         x_in   = x_src;
         for (int j = 0; j < gsrp_pkg::DIV_BITS; j++) begin
            if (s * gsrp_pkg::DIV_BITS + j < DW) begin
               tmp  = {rem_in, x_in[DW-1]};
               x_in = {x_in[DW-2:0], 1'b0};
               if (tmp >= {1'b0, it_src.raw}) begin
                  tmp     = tmp - {1'b0, it_src.raw};
                  x_in[0] = 1'b1;
               end
               rem_in = tmp[RB-1:0];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_item_ff[s].valid <= 1'b0;
         end else if (ce) begin
            div_item_ff[s] <= it_src;
            div_rem_ff[s]  <= rem_in;
            div_x_ff[s]    <= x_in;
         end
      end
   end

   // resistance: (q - 1.0) * load in Q16.16
   gsrp_pkg::item_type m1_in, m1_ff, m2_ff, m3_in, m3_ff;
   logic [DW-1:0]      q_last, t_in, t_ff;
   logic [gsrp_pkg::MUL_LO_W+31:0]      plo_ff;
   logic [DW-gsrp_pkg::MUL_LO_W+31:0]   phi_ff;
   logic [DW+31:0]     rw_full;

   assign q_last = div_x_ff[gsrp_pkg::DIV_STAGES-1];

   always_comb begin
      m1_in = div_item_ff[gsrp_pkg::DIV_STAGES-1];
      if (q_last < DW'(65536)) begin
         t_in      = '0;
         m1_in.sat = 1'b1;
      end else begin
         t_in = q_last - DW'(65536);
      end
   end

   assign rw_full = {phi_ff, {gsrp_pkg::MUL_LO_W{1'b0}}} + (DW+32)'(plo_ff);

   always_comb begin
      m3_in       = m2_ff;
      m3_in.r_ovf = |rw_full[DW+31:48];
      m3_in.sat   = m2_ff.sat | m3_in.r_ovf;
      m3_in.r     = m3_in.r_ovf ? gsrp_pkg::ALL_ONES : rw_full[47:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.valid <= 1'b0;
         m2_ff.valid <= 1'b0;
         m3_ff.valid <= 1'b0;
      end else if (ce) begin
         m1_ff  <= m1_in;
         t_ff   <= t_in;
         m2_ff  <= m1_ff;
         plo_ff <= (gsrp_pkg::MUL_LO_W+32)'(t_ff[gsrp_pkg::MUL_LO_W-1:0]) *
                   (gsrp_pkg::MUL_LO_W+32)'(load_ff);
         phi_ff <= (DW-gsrp_pkg::MUL_LO_W+32)'(t_ff[DW-1:gsrp_pkg::MUL_LO_W]) *
                   (DW-gsrp_pkg::MUL_LO_W+32)'(load_ff);
         m3_ff  <= m3_in;
      end
   end

   // correction: floor(R * 6553600000 / N) as (R * 100000 << 16) / N
   gsrp_pkg::item_type c1_ff, c2_in, c2_ff, c3_in, c3_ff;
   logic [48:0]        pp_ff;
   logic [NW-1:0]      crem0_ff;
   logic [31:0]        cx0_ff;

   always_comb begin
      c2_in       = c1_ff;
      c2_in.c_ovf = ({4'd0, pp_ff} >= {c1_ff.n, 16'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
      end else if (ce) begin
         c1_ff    <= m3_ff;
         pp_ff    <= 49'(m3_ff.r) * 49'(gsrp_pkg::CORR_SCALE);
         c2_ff    <= c2_in;
         crem0_ff <= NW'(pp_ff[48:16]);
         cx0_ff   <= {pp_ff[15:0], 16'd0};
      end
   end

   gsrp_pkg::item_type cd_item_ff [gsrp_pkg::CDIV_STAGES];
   logic [NW-1:0]      cd_rem_ff  [gsrp_pkg::CDIV_STAGES];
   logic [31:0]        cd_x_ff    [gsrp_pkg::CDIV_STAGES];

   for (genvar s = 0; s < gsrp_pkg::CDIV_STAGES; s++) begin : g_cdiv
      gsrp_pkg::item_type it_src;
      logic [NW-1:0]      rem_src, rem_in;
      logic [31:0]        x_src, x_in;
      if (s == 0) begin : g_first
         assign it_src  = c2_ff;
         assign rem_src = crem0_ff;
         assign x_src   = cx0_ff;
      end else begin : g_next
         assign it_src  = cd_item_ff[s-1];
         assign rem_src = cd_rem_ff[s-1];
         assign x_src   = cd_x_ff[s-1];
      end
      always_comb begin
         logic [NW:0] tmp;
         rem_in = rem_src;
         x_in   = x_src;
         for (int j = 0; j < gsrp_pkg::CDIV_BITS; j++) begin
            tmp  = {rem_in, x_in[31]};
            x_in = {x_in[30:0], 1'b0};
            if (tmp >= {1'b0, it_src.n}) begin
               tmp     = tmp - {1'b0, it_src.n};
               x_in[0] = 1'b1;
            end
            rem_in = tmp[NW-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cd_item_ff[s].valid <= 1'b0;
         end else if (ce) begin
            cd_item_ff[s] <= it_src;
            cd_rem_ff[s]  <= rem_in;
            cd_x_ff[s]    <= x_in;
         end
      end
   end

   always_comb begin
      c3_in = cd_item_ff[gsrp_pkg::CDIV_STAGES-1];
      if (!c3_in.r_ovf && c3_in.corr) begin
         if (c3_in.n_bad || c3_in.c_ovf) begin
            c3_in.r   = gsrp_pkg::ALL_ONES;
            c3_in.sat = 1'b1;
         end else begin
            c3_in.r = cd_x_ff[gsrp_pkg::CDIV_STAGES-1];
         end
      end
      c3_in.r_zero = (c3_in.r == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_ff.valid <= 1'b0;
      end else if (ce) begin
         c3_ff <= c3_in;
      end
   end

   // logarithms of R and of R0 (ppm) or the background level (calibration)
   logic [31:0] op2;
   logic [20:0] log_r, log_o;

   assign op2 = (c3_ff.kind == gsrp_pkg::KIND_PPM) ?
                ((r0_ff == '0) ? 32'd1 : r0_ff) : {16'd0, atmo_ff};

   gsrp_log2 u_log_r (.clock(clock), .ce(ce), .x(c3_ff.r), .result(log_r));
   gsrp_log2 u_log_o (.clock(clock), .ce(ce), .x(op2),     .result(log_o));

   gsrp_pkg::item_type lg_item_ff [gsrp_pkg::LOG_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gsrp_pkg::LOG_LAT; i++) begin
            lg_item_ff[i].valid <= 1'b0;
         end
      end else if (ce) begin
         lg_item_ff[0] <= c3_ff;
         for (int i = 1; i < gsrp_pkg::LOG_LAT; i++) begin
            lg_item_ff[i] <= lg_item_ff[i-1];
         end
      end
   end

   // exponent
   gsrp_pkg::item_type lg_last, y1_ff, y2_ff;
   logic signed [22:0] opnd;
   logic signed [18:0] coef;
   logic signed [41:0] prod_ff;
   logic [20:0]        lr1_ff;
   logic signed [gsrp_pkg::Y_W-1:0] y_in, y_ff;
   logic signed [25:0] pd;

   assign lg_last = lg_item_ff[gsrp_pkg::LOG_LAT-1];

   always_comb begin
      if (lg_last.kind == gsrp_pkg::KIND_PPM) begin
         opnd = $signed({2'b00, log_r}) - $signed({2'b00, log_o});
         coef = $signed(gsrp_pkg::PARB_Q16);
      end else begin
         opnd = $signed({2'b00, log_o}) - 23'(gsrp_pkg::LOG2A_I);
         coef = $signed(gsrp_pkg::INVB_Q16);
      end
   end

   // arithmetic shift gives the floor of the Q16 scaling
   assign pd = prod_ff[41:16];

   always_comb begin
      if (y1_ff.kind == gsrp_pkg::KIND_PPM) begin
         y_in = gsrp_pkg::Y_W'(gsrp_pkg::LOG2A_I) - gsrp_pkg::Y_W'(pd);
      end else begin
         y_in = $signed({7'd0, lr1_ff}) - gsrp_pkg::Y_W'(1048576) +
                gsrp_pkg::Y_W'(pd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_ff.valid <= 1'b0;
         y2_ff.valid <= 1'b0;
      end else if (ce) begin
         y1_ff   <= lg_last;
         prod_ff <= 42'(opnd) * 42'(coef);
         lr1_ff  <= log_r;
         y2_ff   <= y1_ff;
         y_ff    <= y_in;
      end
   end

   logic [31:0]                      mant;
   logic signed [gsrp_pkg::Y_W-17:0] ip;

   gsrp_exp2 u_exp (.clock(clock), .ce(ce), .y(y_ff), .mant(mant), .ip(ip));

   gsrp_pkg::item_type ex_item_ff [gsrp_pkg::EXP_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gsrp_pkg::EXP_LAT; i++) begin
            ex_item_ff[i].valid <= 1'b0;
         end
      end else if (ce) begin
         ex_item_ff[0] <= y2_ff;
         for (int i = 1; i < gsrp_pkg::EXP_LAT; i++) begin
            ex_item_ff[i] <= ex_item_ff[i-1];
         end
      end
   end

   // final scaling and result selection
   gsrp_pkg::item_type fin;
   logic signed [13:0] sh, nsh;
   logic [31:0]        exp_val, value_in;
   logic               exp_sat, sat_out;
   logic [1:0]         status_in;

   assign fin = ex_item_ff[gsrp_pkg::EXP_LAT-1];
   assign sh  = 14'(ip) + ((fin.kind == gsrp_pkg::KIND_PPM) ?
                14'(gsrp_pkg::FRAC_BITS) : 14'sd16) - 14'sd30;
   assign nsh = -sh;

   always_comb begin
      exp_sat = 1'b0;
      exp_val = mant;
      if (sh >= 14'sd2) begin
         exp_sat = 1'b1;
         exp_val = gsrp_pkg::ALL_ONES;
      end else if (sh == 14'sd1) begin
         exp_sat = mant[31];
         exp_val = mant[31] ? gsrp_pkg::ALL_ONES : {mant[30:0], 1'b0};
      end else if (sh < 14'sd0) begin
         exp_val = (nsh > 14'sd31) ? 32'd0 : (mant >> nsh[4:0]);
      end
   end

   always_comb begin
      sat_out  = fin.sat;
      value_in = fin.r;
      case (fin.kind)
         gsrp_pkg::KIND_PPM: begin
            if (fin.r_zero) begin
               value_in = gsrp_pkg::ALL_ONES;
               sat_out  = 1'b1;
            end else begin
               value_in = exp_val;
               sat_out  = fin.sat | exp_sat;
            end
         end
         gsrp_pkg::KIND_CAL: begin
            if (fin.r_zero || atmo_ff == '0) begin
               value_in = '0;
            end else begin
               value_in = exp_val;
               sat_out  = fin.sat | exp_sat;
            end
         end
         default: value_in = fin.r;
      endcase
      status_in = sat_out ? gsrp_pkg::ST_SAT : gsrp_pkg::ST_OK;
      if (fin.raw_zero) begin
         value_in  = (fin.kind == gsrp_pkg::KIND_PPM) ? 32'd0 : gsrp_pkg::ALL_ONES;
         status_in = gsrp_pkg::ST_RAW_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (ce) begin
         rsp_tvalid_ff <= fin.valid;
         rsp_value_ff  <= value_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   // checks
   a_raw_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_status_ff == gsrp_pkg::ST_RAW_ZERO) |->
      (rsp_value_ff == 32'd0 || rsp_value_ff == gsrp_pkg::ALL_ONES))
      else $error("raw zero result carries a computed value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff)
      else $error("result valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !ce |=> ($stable(c3_ff) && $stable(lg_last) && $stable(fin)))
      else $error("pipeline moved while the result was stalled");

endmodule

### rtl/gsrp_log2.sv
// ---------------------------------------------------------------------------
// gsrp_log2: pipelined log2 in Q16
// Normalise stage, then one mantissa squaring per stage.
// ---------------------------------------------------------------------------
module gsrp_log2 (
   input  logic        clock,
   input  logic        ce,
   input  logic [31:0] x,
   output logic [20:0] result
);

   logic [4:0]  msb_ff  [gsrp_pkg::LOG_STEPS+1];
   logic [31:0] m_ff    [gsrp_pkg::LOG_STEPS+1];
   logic [15:0] frac_ff [gsrp_pkg::LOG_STEPS+1];
   logic [4:0]  msb_in;

   always_comb begin
      msb_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            msb_in = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         msb_ff[0]  <= msb_in;
         m_ff[0]    <= x << (5'd31 - msb_in);
         frac_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= gsrp_pkg::LOG_STEPS; k++) begin : g_sq
      logic [32:0] st;
      assign st = gsrp_pkg::log2_sq_step(m_ff[k-1]);
      always_ff @(posedge clock) begin
         if (ce) begin
            msb_ff[k]  <= msb_ff[k-1];
            m_ff[k]    <= st[31:0];
            frac_ff[k] <= {frac_ff[k-1][14:0], st[32]};
         end
      end
   end

   assign result = {msb_ff[gsrp_pkg::LOG_STEPS], frac_ff[gsrp_pkg::LOG_STEPS]};

endmodule

### rtl/gsrp_exp2.sv
// ---------------------------------------------------------------------------
// gsrp_exp2: pipelined exp2 mantissa
// Splits a Q16 exponent; each stage multiplies by 2^(2^-k) in Q30 when
// the matching fraction bit is set.
// ---------------------------------------------------------------------------
module gsrp_exp2 (
   input  logic                            clock,
   input  logic                            ce,
   input  logic signed [gsrp_pkg::Y_W-1:0] y,
   output logic [31:0]                     mant,
   output logic signed [gsrp_pkg::Y_W-17:0] ip
);

   logic [31:0]                      m_ff  [gsrp_pkg::EXP_STEPS+1];
   logic [15:0]                      fr_ff [gsrp_pkg::EXP_STEPS+1];
   logic signed [gsrp_pkg::Y_W-17:0] ip_ff [gsrp_pkg::EXP_STEPS+1];

   always_ff @(posedge clock) begin
      if (ce) begin
         m_ff[0]  <= 32'd1 << 30;
         fr_ff[0] <= y[15:0];
         ip_ff[0] <= y[gsrp_pkg::Y_W-1:16];
      end
   end

   for (genvar k = 1; k <= gsrp_pkg::EXP_STEPS; k++) begin : g_mul
      localparam logic [31:0] COEF = gsrp_pkg::exp2_coef_f(k);
      logic [63:0] prod;
      assign prod = 64'(m_ff[k-1]) * 64'(COEF);
      always_ff @(posedge clock) begin
         if (ce) begin
            m_ff[k]  <= fr_ff[k-1][16-k] ? prod[61:30] : m_ff[k-1];
            fr_ff[k] <= fr_ff[k-1];
            ip_ff[k] <= ip_ff[k-1];
         end
      end
   end

   assign mant = m_ff[gsrp_pkg::EXP_STEPS];
   assign ip   = ip_ff[gsrp_pkg::EXP_STEPS];

endmodule
